@@ design/alf_pkg.sv @@
// alf_pkg: shared types, constants and helpers for the associated legendre block
// used by alf_div and associated_legendre_function; no dependencies
package alf_pkg;

  localparam int MAX_DEGREE_DEF = 8;

  localparam logic signed [63:0] LIM     = 64'sh2000_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q30 = 64'sh0000_0000_4000_0000;
  localparam logic signed [63:0] OUT_MAX = 64'sh007F_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = -64'sh0080_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_RND,
    ST_MH,
    ST_ML,
    ST_MS,
    ST_DF,
    ST_RINIT,
    ST_RK,
    ST_RB,
    ST_DIV,
    ST_FIN
  } alf_state_t;

  function automatic logic signed [63:0] clamp61(input logic signed [69:0] a);
    logic signed [63:0] r;
    if (a > 70'(LIM)) begin
      r = LIM;
    end else if (a < -70'(LIM)) begin
      r = -LIM;
    end else begin
      r = a[63:0];
    end
    return r;
  endfunction

endpackage

@@ design/alf_div.sv @@
// alf_div: bit-serial divider by a small divisor, rounding to nearest, ties away from zero
// depends on alf_pkg
module alf_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [3:0]         den,
  output logic               done,
  output logic signed [63:0] quo
);
  import alf_pkg::*;

  logic        busy;
  logic        neg;
  logic [62:0] dq;
  logic [3:0]  rem;
  logic [3:0]  dreg;
  logic [5:0]  cnt;
  logic [62:0] mag;
  logic [4:0]  trial;
  logic        ge;

  assign mag   = 63'(num < 0 ? -num : num) + 63'(den >> 1);
  assign trial = {rem, dq[62]};
  assign ge    = trial >= {1'b0, dreg};
  assign quo   = neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd63;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq   <= mag;
      rem  <= '0;
      dreg <= den;
      neg  <= num < 0;
    end else if (busy) begin
      dq  <= {dq[61:0], ge};
      rem <= ge ? 4'(trial - {1'b0, dreg}) : trial[3:0];
    end
  end

endmodule

@@ design/associated_legendre_function.sv @@
// associated_legendre_function: P_n^m(x) without condon-shortley sign, fixed point
// depends on alf_pkg and alf_div
//
// input stream s_*: one transaction carries degree n, order m and argument x (Q2.30).
// output stream m_*: one transaction per input with the value in units of 2^-32.
// one shared 34x33 multiplier, a small constant multiplier and a bit-serial divider
// run under a sequencer; the block takes one item at a time.
// from input to output register the sequencer runs the bit-pair square root,
// a split Q30 product per power of s, the double-factorial steps, and per
// recurrence step a split Q30 product plus a serial division, which sets the rate.
// n above MAX_DEGREE or m above n goes straight to the output and gives zero.
// the result sits in an output register; the next input is taken while it waits,
// and a finished item holds until m_tready frees that register.
// synchronous reset returns the sequencer to idle and drops m_tvalid.
module associated_legendre_function #(
  parameter int MAX_DEGREE = alf_pkg::MAX_DEGREE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // degree[3:0], order[7:4], argument[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // value[55:0]
);
  import alf_pkg::*;

  alf_state_t state, state_next;

  logic [3:0]         degree;
  logic [3:0]         order;
  logic signed [31:0] argument;
  logic signed [31:0] x_in;

  logic [3:0]         n;
  logic [3:0]         m;
  logic signed [31:0] x;
  logic [30:0]        s;
  logic [62:0]        v;
  logic [62:0]        r;
  logic [4:0]         k;
  logic [3:0]         i;
  logic [3:0]         l;
  logic               ret_rec;
  logic signed [63:0] mop;
  logic signed [63:0] p1;
  logic signed [63:0] p2;
  logic signed [66:0] ph;
  logic signed [66:0] pl;
  logic               out_valid;
  logic [55:0]        out_data;

  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] mul_p;
  logic signed [63:0] sm_a;
  logic [4:0]         sm_k;
  logic signed [69:0] sm_p;
  logic signed [63:0] sm_c;
  logic signed [63:0] ms_res;
  logic signed [63:0] t0;
  logic [62:0]        bitv;
  logic [62:0]        rsum;
  logic               accept;
  logic               zero_case;
  logic               fin_go;
  logic               div_done;
  logic signed [63:0] div_q;

  assign degree   = s_tdata[3:0];
  assign order    = s_tdata[7:4];
  assign argument = s_tdata[39:8];
  assign x_in     = (argument > 32'sh4000_0000) ? 32'sh4000_0000 :
                    (argument < -32'sh4000_0000) ? -32'sh4000_0000 : argument;

  assign s_tready  = state == ST_IDLE;
  assign accept    = s_tvalid && s_tready;
  assign zero_case = (degree > 4'(MAX_DEGREE)) || (order > degree);
  assign fin_go    = !out_valid || m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // shared multiplier
  always_comb begin
    mul_a = 34'(x);
    mul_b = 33'(x);
    case (state)
      ST_MH: mul_a = 34'(mop >>> 30);
      ST_ML: mul_a = $signed({4'b0, mop[29:0]});
      default: mul_a = 34'(x);
    endcase
    if (state == ST_MH || state == ST_ML) begin
      mul_b = ret_rec ? 33'(x) : $signed({2'b0, s});
    end
  end
  assign mul_p = 67'(mul_a) * 67'(mul_b);

  // small constant multiplier with saturation
  always_comb begin
    sm_a = p1;
    sm_k = 5'({i, 1'b0} - 5'd1);
    case (state)
      ST_RK: sm_k = 5'({l, 1'b0} - 5'd1);
      ST_RB: begin
        sm_a = p2;
        sm_k = 5'(l) + 5'(m) - 5'd1;
      end
      default: sm_k = 5'({i, 1'b0} - 5'd1);
    endcase
  end
  assign sm_p = 70'(sm_a) * $signed({65'b0, sm_k});
  assign sm_c = clamp61(sm_p);

  assign ms_res = clamp61(70'(ph) + ((70'(pl) + 70'sd536870912) >>> 30));
  assign t0     = clamp61(70'(mop) - 70'(sm_c));
  assign bitv   = 63'(1) << {k, 1'b0};
  assign rsum   = r + bitv;

  alf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_RB),
    .num   (t0),
    .den   (l - m),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = zero_case ? ST_FIN : ST_SQ;
      ST_SQ:    state_next = ST_ROOT;
      ST_ROOT:  if (k == 5'd0) state_next = ST_RND;
      ST_RND:   state_next = (m == 4'd0) ? ST_RINIT : ST_MH;
      ST_MH:    state_next = ST_ML;
      ST_ML:    state_next = ST_MS;
      ST_MS: begin
        if (ret_rec) begin
          state_next = ST_RB;
        end else if (i == m) begin
          state_next = ST_DF;
        end else begin
          state_next = ST_MH;
        end
      end
      ST_DF:    if (i == m) state_next = ST_RINIT;
      ST_RINIT: state_next = (m == n) ? ST_FIN : ST_RK;
      ST_RK:    state_next = ST_MH;
      ST_RB:    state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = (l == n) ? ST_FIN : ST_RK;
      ST_FIN:   if (fin_go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FIN && fin_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        n  <= degree;
        m  <= order;
        x  <= x_in;
        p1 <= '0;
      end
      ST_SQ: begin
        v <= (63'(1) << 60) - mul_p[62:0];
        r <= '0;
        k <= 5'd31;
      end
      ST_ROOT: begin
        if (v >= rsum) begin
          v <= v - rsum;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        k <= k - 5'd1;
      end
      ST_RND: begin
        s       <= 31'(r) + 31'(v > r);
        mop     <= ONE_Q30;
        ret_rec <= 1'b0;
        i       <= 4'd1;
        p1      <= ONE_Q30 <<< 2;
      end
      ST_MH: ph <= mul_p;
      ST_ML: pl <= mul_p;
      ST_MS: begin
        mop <= ms_res;
        if (!ret_rec) begin
          if (i == m) begin
            p1 <= ms_res <<< 2;
            i  <= 4'd1;
          end else begin
            i <= i + 4'd1;
          end
        end
      end
      ST_DF: begin
        p1 <= sm_c;
        i  <= i + 4'd1;
      end
      ST_RINIT: begin
        l  <= m + 4'd1;
        p2 <= '0;
      end
      ST_RK: begin
        mop     <= sm_c;
        ret_rec <= 1'b1;
      end
      ST_RB: ;
      ST_DIV: begin
        if (div_done) begin
          p2 <= p1;
          p1 <= div_q;
          l  <= l + 4'd1;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_data <= (p1 > OUT_MAX) ? OUT_MAX[55:0] :
                      (p1 < OUT_MIN) ? OUT_MIN[55:0] : p1[55:0];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_zero_fast: assert property (@(posedge clk) disable iff (rst)
    (accept && (order > degree)) |=> (state == ST_FIN))
    else $error("order above degree did not go straight to output");

  a_div_next: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_done) |=> (state == ST_RK || state == ST_FIN))
    else $error("sequencer lost after division");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RND) |-> (r <= 63'(ONE_Q30)))
    else $error("square root out of range");
`endif

endmodule

@@ tb/sv/tb_associated_legendre_function.sv @@
// testbench for associated_legendre_function: streams (degree, order, argument) items,
// predicts P_n^m(x) with a local fixed-point recurrence and checks every result.
// depends on alf_pkg and the design sources
`timescale 1ns / 100ps

module tb_associated_legendre_function;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [31:0] argument;
    logic [3:0]  order;
    logic [3:0]  degree;
  } legendre_req_t;

  localparam int NUM_RANDOM = 400;
  localparam int PHASES     = 4;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  legendre_req_t pending_reqs[$];
  logic [55:0]   expected_values[$];
  int            total_reqs;
  int            accepted_cnt;
  int            checked_cnt;
  int            error_cnt;
  int            send_idle_pct;
  int            recv_stall_pct;

  associated_legendre_function uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic wide_t clip61(input wide_t a);
    wide_t lim;
    lim = wide_t'(alf_pkg::LIM);
    if (a > lim) return lim;
    if (a < -lim) return -lim;
    return a;
  endfunction

  // round(a*x/2^30), ties toward +inf
  function automatic wide_t scale_q30(input wide_t a, input wide_t x);
    wide_t p;
    p = a * x + (wide_t'(1) <<< 29);
    return clip61(p >>> 30);
  endfunction

  // rounding division, ties away from zero
  function automatic wide_t div_nearest(input wide_t a, input wide_t d);
    wide_t mag;
    mag = (a < 0) ? -a : a;
    mag = (mag + d / 2) / d;
    return (a < 0) ? -mag : mag;
  endfunction

  function automatic longint unsigned sqrt_nearest(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (v > r) r++;
    return r;
  endfunction

  function automatic logic [55:0] legendre_value(input legendre_req_t req);
    wide_t x, s, pw, dfac, cur, prev, a, b, nxt, res;
    int n, m, l;
    n = req.degree;
    m = req.order;
    x = wide_t'($signed(req.argument));
    if (x > 128'sd1073741824) x = 128'sd1073741824;
    if (x < -128'sd1073741824) x = -128'sd1073741824;
    if (n > alf_pkg::MAX_DEGREE_DEF || m > n) return '0;
    s = wide_t'(sqrt_nearest(64'((wide_t'(1) <<< 60) - x * x)));
    pw = wide_t'(1) <<< 30;
    dfac = 1;
    for (int i = 1; i <= m; i++) begin
      pw = scale_q30(pw, s);
      dfac = clip61(dfac * (2 * i - 1));
    end
    cur = clip61(pw * 4 * dfac);
    prev = 0;
    for (l = m + 1; l <= n; l++) begin
      a = scale_q30(clip61(cur * (2 * l - 1)), x);
      b = clip61(prev * (l + m - 1));
      nxt = div_nearest(clip61(a - b), l - m);
      prev = cur;
      cur = nxt;
    end
    res = cur;
    if (res > wide_t'(alf_pkg::OUT_MAX)) res = wide_t'(alf_pkg::OUT_MAX);
    if (res < wide_t'(alf_pkg::OUT_MIN)) res = wide_t'(alf_pkg::OUT_MIN);
    return res[55:0];
  endfunction

  function automatic legendre_req_t make_req(input int n, input int m, input logic [31:0] x);
    legendre_req_t r;
    r.degree = n[3:0];
    r.order = m[3:0];
    r.argument = x;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin
    int n, m, k;
    logic [31:0] x;
    rst = 1'b1;
    pending_reqs.push_back(make_req(0, 0, 32'h0000_0000));
    pending_reqs.push_back(make_req(1, 0, 32'h4000_0000));
    pending_reqs.push_back(make_req(1, 1, 32'hC000_0000));
    pending_reqs.push_back(make_req(8, 8, 32'h0000_0000));
    pending_reqs.push_back(make_req(8, 8, 32'h4000_0000));
    pending_reqs.push_back(make_req(8, 0, 32'h4000_0000));
    pending_reqs.push_back(make_req(8, 0, 32'hC000_0000));
    pending_reqs.push_back(make_req(8, 1, 32'h2000_0000));
    pending_reqs.push_back(make_req(7, 3, 32'hE000_0001));
    pending_reqs.push_back(make_req(8, 4, 32'h3FFF_FFFF));
    pending_reqs.push_back(make_req(8, 7, 32'hC000_0001));
    pending_reqs.push_back(make_req(5, 2, 32'h7FFF_FFFF));
    pending_reqs.push_back(make_req(5, 2, 32'h8000_0000));
    pending_reqs.push_back(make_req(6, 1, 32'h4000_0001));
    pending_reqs.push_back(make_req(3, 4, 32'h1000_0000));
    pending_reqs.push_back(make_req(0, 15, 32'h1000_0000));
    pending_reqs.push_back(make_req(9, 0, 32'h1000_0000));
    pending_reqs.push_back(make_req(15, 15, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(8, 2, 32'h0000_0001));
    pending_reqs.push_back(make_req(2, 2, 32'hFFFF_FFFF));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      k = $urandom_range(99);
      if (k < 80) begin
        n = $urandom_range(alf_pkg::MAX_DEGREE_DEF);
        m = $urandom_range(n);
      end else begin
        n = $urandom_range(15);
        m = $urandom_range(15);
      end
      k = $urandom_range(99);
      if (k < 70) x = $urandom_range(32'h8000_0000) - 32'h4000_0000;
      else if (k < 80) x = ($urandom_range(1)) ? 32'h4000_0000 : 32'hC000_0000;
      else x = $urandom;
      pending_reqs.push_back(make_req(n, m, x));
    end
    total_reqs = pending_reqs.size();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (accepted_cnt == total_reqs);
    wait (expected_values.size() == 0);
    repeat (20) @(posedge clk);
    $display("%0d items sent, %0d results checked, idling phases %0d", total_reqs,
             checked_cnt, PHASES);
    if (error_cnt == 0 && expected_values.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // idling per phase: none, sender only, receiver only, both
  always_comb begin
    case ((total_reqs == 0) ? 0 : accepted_cnt * PHASES / total_reqs)
      1: begin send_idle_pct = 46; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 46; end
      3: begin send_idle_pct = 28; recv_stall_pct = 28; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  end

  // driver
  always @(posedge clk) begin
    legendre_req_t r;
    bit busy;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      m_tready <= 1'b0;
      accepted_cnt <= 0;
    end else begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        r = s_tdata;
        expected_values.push_back(legendre_value(r));
        accepted_cnt <= accepted_cnt + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata <= pending_reqs.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [55:0] want;
    if (rst) begin
      checked_cnt <= 0;
      error_cnt <= 0;
    end else if (m_tvalid && m_tready) begin
      checked_cnt <= checked_cnt + 1;
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        error_cnt <= error_cnt + 1;
      end else begin
        want = expected_values.pop_front();
        if (m_tdata !== want) begin
          $display("%0t: value mismatch, expected %h, actual %h", $time, want, m_tdata);
          error_cnt <= error_cnt + 1;
        end
      end
    end
  end

endmodule
